/* design/altf_pkg.sv */
// Shared types, codes and constants for the application-layer transaction channel.
package altf_pkg;

  localparam int MAX_RETRIES = 255;
  localparam int RETRY_W     = 8;
  localparam int SEQ_W       = 4;

  // Channel states, encoded as reported on state_out
  typedef enum logic [2:0] {
    ST_IDLE       = 3'd0,
    ST_SEND       = 3'd1,
    ST_SEND_CONF  = 3'd2,
    ST_SEND_EXP   = 3'd3,
    ST_CANCELED   = 3'd4,
    ST_WAIT_CONF  = 3'd5,
    ST_WAIT_FIRST = 3'd6,
    ST_WAIT_FINAL = 3'd7
  } chan_state_t;

  // Event kinds
  typedef enum logic [2:0] {
    EV_SEND      = 3'd0,
    EV_CANCEL    = 3'd1,
    EV_SEND_OK   = 3'd2,
    EV_SEND_FAIL = 3'd3,
    EV_CONFIRM   = 3'd4,
    EV_RESPONSE  = 3'd5,
    EV_TIMEOUT   = 3'd6,
    EV_REQ_SEEN  = 3'd7
  } event_kind_t;

  // Function classes of a send
  localparam logic [2:0] FC_CONFIRM  = 3'd0;
  localparam logic [2:0] FC_RESPONSE = 3'd1;
  localparam logic [2:0] FC_UNSOL    = 3'd2;
  localparam logic [2:0] FC_DO_NOACK = 3'd3;

  typedef enum logic [2:0] {
    ACT_NONE    = 3'd0,
    ACT_TX      = 3'd1,
    ACT_RETX    = 3'd2,
    ACT_SUCCESS = 3'd3,
    ACT_FAIL    = 3'd4,
    ACT_PARTIAL = 3'd5,
    ACT_FINAL   = 3'd6
  } action_t;

  typedef enum logic [1:0] {
    TMR_NONE   = 2'd0,
    TMR_START  = 2'd1,
    TMR_CANCEL = 2'd2
  } timer_cmd_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_STATE    = 3'd1,
    ERR_ARG      = 3'd2,
    ERR_CONFIRM  = 3'd3,
    ERR_FIR      = 3'd4,
    ERR_SEQ      = 3'd5,
    ERR_RESPONSE = 3'd6,
    ERR_NOREQ    = 3'd7
  } err_code_t;

  // One event request as held in the input register
  typedef struct packed {
    logic [2:0]         kind;
    logic [2:0]         function_class;
    logic               first_flag;
    logic               final_flag;
    logic               confirm_flag;
    logic [RETRY_W-1:0] retry_count;
    logic [SEQ_W-1:0]   seq_in;
  } req_t;

  // One result as held in the output register
  typedef struct packed {
    action_t          action;
    timer_cmd_t       timer_cmd;
    logic [SEQ_W-1:0] seq_out;
    err_code_t        error_code;
    chan_state_t      state_out;
  } res_t;

endpackage

/* design/altf_in_reg.sv */
// Input register stage for event requests.
module altf_in_reg (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  altf_pkg::req_t in_req,
  input  logic          advance,
  output logic          req_valid,
  output altf_pkg::req_t req
);
  import altf_pkg::*;

  logic valid_r;
  logic valid_nxt;
  req_t req_r;
  logic load;

  // Take a new request when empty or when the held one moves on
  assign load      = !valid_r || advance;
  assign in_stall  = !load;
  assign valid_nxt = load ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      req_r <= in_req;
    end
  end

  assign req_valid = valid_r;
  assign req       = req_r;

endmodule

/* design/altf_core.sv */
// Channel state registers and the per-event next-state and result logic.
module altf_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  altf_pkg::req_t req,
  output altf_pkg::res_t res
);
  import altf_pkg::*;

  chan_state_t        state_r, state_nxt;
  logic [SEQ_W-1:0]   seq_r, seq_nxt;
  logic               seq_valid_r, seq_valid_nxt;
  logic [RETRY_W-1:0] retries_r, retries_nxt;

  err_code_t          err;
  action_t            action;
  timer_cmd_t         timer_cmd;
  logic               is_send_st;
  logic               is_wait_st;
  logic               retry_ok;
  logic               fir_expect;
  logic [15:0]        rc_ext;
  logic [RETRY_W-1:0] budget;
  logic [SEQ_W-1:0]   seq_inc;

  assign is_send_st = state_r inside {ST_SEND, ST_SEND_CONF, ST_SEND_EXP};
  assign is_wait_st = state_r inside {ST_WAIT_CONF, ST_WAIT_FIRST, ST_WAIT_FINAL};
  assign retry_ok   = (retries_r != '0);
  assign fir_expect = (state_r == ST_WAIT_FIRST);
  assign seq_inc    = seq_r + SEQ_W'(1);

  // Retry budget is the smaller of the request and the channel limit
  assign rc_ext = 16'(req.retry_count);
  assign budget = (rc_ext < 16'(MAX_RETRIES)) ? req.retry_count : RETRY_W'(MAX_RETRIES);

  // Legality check of the event against the current state
  always_comb begin
    err = ERR_NONE;
    case (req.kind)
      EV_SEND: begin
        if (state_r != ST_IDLE) begin
          err = ERR_STATE;
        end else if (req.function_class == FC_CONFIRM) begin
          err = ERR_ARG;
        end else if (req.function_class == FC_RESPONSE) begin
          if (req.first_flag && !seq_valid_r) err = ERR_NOREQ;
        end else if (req.function_class != FC_UNSOL) begin
          if (req.confirm_flag) err = ERR_ARG;
        end
      end
      EV_CANCEL: begin
        if (state_r inside {ST_IDLE, ST_WAIT_FIRST, ST_WAIT_FINAL}) err = ERR_STATE;
      end
      EV_SEND_OK, EV_SEND_FAIL: begin
        if (state_r == ST_IDLE || is_wait_st) err = ERR_STATE;
      end
      EV_CONFIRM: begin
        if (state_r != ST_WAIT_CONF || req.seq_in != seq_r) err = ERR_CONFIRM;
      end
      EV_RESPONSE: begin
        if (!(state_r inside {ST_WAIT_FIRST, ST_WAIT_FINAL})) begin
          err = ERR_RESPONSE;
        end else if (req.seq_in != seq_r) begin
          err = ERR_SEQ;
        end else if (req.first_flag != fir_expect) begin
          err = ERR_FIR;
        end
      end
      EV_TIMEOUT: begin
        if (!is_wait_st) err = ERR_STATE;
      end
      default: err = ERR_NONE;
    endcase
  end

  // Next state of the channel
  always_comb begin
    state_nxt     = state_r;
    seq_nxt       = seq_r;
    seq_valid_nxt = seq_valid_r;
    retries_nxt   = retries_r;
    if (err == ERR_NONE) begin
      case (req.kind)
        EV_SEND: begin
          retries_nxt = budget;
          if (!(req.function_class == FC_RESPONSE && req.first_flag)) begin
            seq_nxt       = seq_inc;
            seq_valid_nxt = 1'b1;
          end
          if (req.function_class == FC_RESPONSE || req.function_class == FC_UNSOL) begin
            state_nxt = req.confirm_flag ? ST_SEND_CONF : ST_SEND;
          end else if (req.function_class == FC_DO_NOACK) begin
            state_nxt = ST_SEND;
          end else begin
            state_nxt = ST_SEND_EXP;
          end
        end
        EV_CANCEL: begin
          state_nxt = (state_r == ST_WAIT_CONF) ? ST_IDLE : ST_CANCELED;
        end
        EV_SEND_OK: begin
          case (state_r)
            ST_SEND_CONF: state_nxt = ST_WAIT_CONF;
            ST_SEND_EXP:  state_nxt = ST_WAIT_FIRST;
            default:      state_nxt = ST_IDLE;
          endcase
        end
        EV_SEND_FAIL, EV_TIMEOUT: begin
          if (state_r == ST_CANCELED || !retry_ok) begin
            state_nxt = ST_IDLE;
          end else begin
            retries_nxt = retries_r - RETRY_W'(1);
            case (state_r)
              ST_WAIT_CONF:                 state_nxt = ST_SEND_CONF;
              ST_WAIT_FIRST, ST_WAIT_FINAL: state_nxt = ST_SEND_EXP;
              default:                      state_nxt = state_r;
            endcase
          end
        end
        EV_CONFIRM: state_nxt = ST_IDLE;
        EV_RESPONSE: begin
          if (req.final_flag) begin
            state_nxt = ST_IDLE;
          end else begin
            state_nxt     = ST_WAIT_FINAL;
            seq_nxt       = seq_inc;
            seq_valid_nxt = 1'b1;
          end
        end
        default: begin
          seq_nxt       = req.seq_in;
          seq_valid_nxt = 1'b1;
        end
      endcase
    end
  end

  // Action and timer command of the event
  always_comb begin
    action    = ACT_NONE;
    timer_cmd = TMR_NONE;
    if (err == ERR_NONE) begin
      case (req.kind)
        EV_SEND: action = ACT_TX;
        EV_CANCEL: begin
          if (state_r == ST_WAIT_CONF) begin
            action    = ACT_FAIL;
            timer_cmd = TMR_CANCEL;
          end
        end
        EV_SEND_OK: begin
          case (state_r)
            ST_SEND:                   action = ACT_SUCCESS;
            ST_CANCELED:               action = ACT_FAIL;
            ST_SEND_CONF, ST_SEND_EXP: timer_cmd = TMR_START;
            default:                   action = ACT_NONE;
          endcase
        end
        EV_SEND_FAIL, EV_TIMEOUT: begin
          action = (state_r != ST_CANCELED && retry_ok) ? ACT_RETX : ACT_FAIL;
        end
        EV_CONFIRM: begin
          action    = ACT_SUCCESS;
          timer_cmd = TMR_CANCEL;
        end
        EV_RESPONSE: begin
          action    = req.final_flag ? ACT_FINAL : ACT_PARTIAL;
          timer_cmd = req.final_flag ? TMR_CANCEL : TMR_START;
        end
        default: action = ACT_NONE;
      endcase
    end
  end

  // Channel state advances only when the result is registered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      seq_r       <= '0;
      seq_valid_r <= 1'b0;
      retries_r   <= '0;
    end else if (fire) begin
      state_r     <= state_nxt;
      seq_r       <= seq_nxt;
      seq_valid_r <= seq_valid_nxt;
      retries_r   <= retries_nxt;
    end
  end

  assign res.action     = action;
  assign res.timer_cmd  = timer_cmd;
  assign res.seq_out    = seq_nxt;
  assign res.error_code = err;
  assign res.state_out  = state_nxt;

endmodule

/* design/altf_out_reg.sv */
// Result register stage with downstream stall handling.
module altf_out_reg (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           res_valid,
  input  altf_pkg::res_t res,
  output logic           advance,
  output logic           out_valid,
  input  logic           out_stall,
  output altf_pkg::res_t out_res
);
  import altf_pkg::*;

  logic valid_r;
  logic valid_nxt;
  res_t res_r;

  // Register is free when empty or when its result is being taken
  assign advance   = !valid_r || !out_stall;
  assign valid_nxt = advance ? res_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      res_r <= res;
    end
  end

  assign out_valid = valid_r;
  assign out_res   = res_r;

endmodule

/* design/app_layer_transaction_fsm.sv */
// Top level of the application-layer transaction channel.
// Requests pass from the input register through the core into the result register.
// Throughput: one request per cycle unless out_stall holds a result; the channel state
// updates in the same cycle a result is registered, so back-to-back requests see it.
// Reset (rst_n low, synchronous): both stages empty, channel idle, sequence 0,
// no request seen, no retries left.
module app_layer_transaction_fsm (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [2:0]                      in_kind,
  input  logic [2:0]                      in_function_class,
  input  logic                            in_first_flag,
  input  logic                            in_final_flag,
  input  logic                            in_confirm_flag,
  input  logic [altf_pkg::RETRY_W-1:0]    in_retry_count,
  input  logic [altf_pkg::SEQ_W-1:0]      in_seq_in,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [2:0]                      out_action,
  output logic [1:0]                      out_timer_cmd,
  output logic [altf_pkg::SEQ_W-1:0]      out_seq_out,
  output logic [2:0]                      out_error_code,
  output logic [2:0]                      out_state_out
);
  import altf_pkg::*;

  req_t in_req;
  req_t req;
  res_t res;
  res_t out_res;
  logic req_valid;
  logic advance;
  logic fire;

  // Pack the request fields
  assign in_req.kind           = in_kind;
  assign in_req.function_class = in_function_class;
  assign in_req.first_flag     = in_first_flag;
  assign in_req.final_flag     = in_final_flag;
  assign in_req.confirm_flag   = in_confirm_flag;
  assign in_req.retry_count    = in_retry_count;
  assign in_req.seq_in         = in_seq_in;

  assign fire = req_valid && advance;

  altf_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .advance   (advance),
    .req_valid (req_valid),
    .req       (req)
  );

  altf_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .req   (req),
    .res   (res)
  );

  altf_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (req_valid),
    .res       (res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  // Unpack the result fields
  assign out_action     = out_res.action;
  assign out_timer_cmd  = out_res.timer_cmd;
  assign out_seq_out    = out_res.seq_out;
  assign out_error_code = out_res.error_code;
  assign out_state_out  = out_res.state_out;

`ifndef SYNTH
  // A rejected event neither acts nor touches the timer
  a_err_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_error_code != ERR_NONE) |->
      (out_action == ACT_NONE && out_timer_cmd == TMR_NONE))
    else $error("error result carries an action or timer command");

  // A transmit or retransmit always leaves the channel in a send state
  a_tx_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_action == ACT_TX || out_action == ACT_RETX)) |->
      (out_state_out == ST_SEND || out_state_out == ST_SEND_CONF ||
       out_state_out == ST_SEND_EXP))
    else $error("transmit result outside a send state");

  // Input only stalls while a request is held and the result side is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (req_valid && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // A partial response comes with a timer restart and leaves the channel waiting for the final
  a_resp_timer: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_action == ACT_PARTIAL) |->
      (out_timer_cmd == TMR_START && out_state_out == ST_WAIT_FINAL))
    else $error("partial response without timer restart");
`endif

endmodule
